@@ rtl/core/iol_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package iol_pkg;

	// request codes
	localparam logic [2:0] REQ_INS_FRONT = 3'd0;
	localparam logic [2:0] REQ_INS_BACK  = 3'd1;
	localparam logic [2:0] REQ_INS_POS   = 3'd2;
	localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
	localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
	localparam logic [2:0] REQ_DEL_POS   = 3'd5;
	localparam logic [2:0] REQ_DUMP      = 3'd6;

	// status codes
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	// cell operations
	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD = 2'd0;
	localparam cell_op_t CELL_INS  = 2'd1;
	localparam cell_op_t CELL_DEL  = 2'd2;
	localparam cell_op_t CELL_ROT  = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t    op;
		logic [31:0] new_value;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/iol_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module iol_cell #(
	parameter int IDX = 0,
	parameter int IW  = 5
) (
	input  wire                    clk,
	input  iol_pkg::cell_ctl_t     ctl,
	input  wire        [IW-1:0]    pos,
	input  wire        [IW-1:0]    tail,
	input  wire        [31:0]      head,
	input  wire        [31:0]      left,
	input  wire        [31:0]      right,
	output logic       [31:0]      value
);
	import iol_pkg::*;

	localparam logic [IW-1:0] MyIdx = IW'(IDX);

	logic [31:0] value_q;
	logic [31:0] value_d;

	// pick the next entry: shift back, shift forward or rotate through the head
	always_comb begin
		value_d = value_q;
		case (ctl.op)
			CELL_INS: begin
				if (MyIdx > pos)
					value_d = left;
				else if (MyIdx == pos)
					value_d = ctl.new_value;
			end
			CELL_DEL: begin
				if (MyIdx >= pos)
					value_d = right;
			end
			CELL_ROT: begin
				if (MyIdx == tail)
					value_d = head;
				else if (MyIdx < tail)
					value_d = right;
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
endmodule
`default_nettype wire

@@ rtl/core/iol_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
module iol_chain #(
	parameter int DEPTH = 16,
	parameter int IW    = 5
) (
	input  wire                    clk,
	input  iol_pkg::cell_ctl_t     ctl,
	input  wire        [IW-1:0]    pos,
	input  wire        [IW-1:0]    tail,
	output logic       [31:0]      head
);
	import iol_pkg::*;

	logic [31:0] vals [DEPTH];

	// link each cell to its neighbors; the ends see the insert value and zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] left_w;
		logic [31:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = ctl.new_value;
		end else begin : g_mid_l
			assign left_w = vals[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = 32'd0;
		end else begin : g_mid_r
			assign right_w = vals[i+1];
		end
		iol_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (pos),
			.tail  (tail),
			.head  (vals[0]),
			.left  (left_w),
			.right (right_w),
			.value (vals[i])
		);
	end

	assign head = vals[0];
endmodule
`default_nettype wire

@@ rtl/core/indexed_ordered_list_top.sv @@
// Indexed ordered list of up to LIST_DEPTH signed 32-bit entries, front at entry 0.
// Input channel (in_valid/in_ready) carries one request item: req_type, new_value,
// position. Output channel (out_valid/out_ready) carries result items: status,
// item_value, item_valid, last_item, entry_count.
// Inserts and deletes shift all entries from the target position onward in the cell chain
// together, so such an item gets its single result on the output in the next cycle.
// A new item is accepted while a result waits only if the output register frees
// in the same cycle; throughput is one item per cycle while the receiver keeps up and no dump runs.
// A dump of N entries is taken as one item, then gives one chain rotation per result;
// a dump of an empty list gives a single result with item_valid low. No new item is accepted
// until the dump's last result has been handed to the output register.
// A stalled receiver holds the output register and freezes the chain.
// Reset empties the list and drops any pending result; entry contents are not
// cleared, since no entry beyond the count is ever read.
`timescale 1ns / 1ps
`default_nettype none
module indexed_ordered_list_top #(
	parameter int LIST_DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire        [2:0]   req_type,
	input  wire signed [31:0]  new_value,
	input  wire        [4:0]   position,
	output logic               out_valid,
	input  wire                out_ready,
	output logic       [1:0]   status,
	output logic signed [31:0] item_value,
	output logic               item_valid,
	output logic               last_item,
	output logic       [4:0]   entry_count
);
	import iol_pkg::*;

	localparam int CW   = $clog2(LIST_DEPTH + 1);
	localparam int CmpW = (CW > 5) ? CW : 5;
	localparam logic [CmpW-1:0] DepthC = CmpW'(LIST_DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic            state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   dump_idx_q;
	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [31:0]     item_value_q;
	logic            item_valid_q;
	logic            last_q;
	logic [4:0]      entry_count_q;

	logic            out_free;
	logic            accept;
	logic [CmpW-1:0] cnt_ext;
	logic [CmpW-1:0] pos_ext;
	logic [CmpW-1:0] tgt;
	cell_op_t        req_op;
	logic [1:0]      req_status;
	logic [CmpW-1:0] req_count;
	logic            req_dump;
	cell_ctl_t       ctl;
	logic [CW-1:0]   tail;
	logic [31:0]     head;
	logic            dump_last;
	logic [CmpW-1:0] dump_cnt_ext;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	assign cnt_ext = CmpW'(count_q);
	assign pos_ext = CmpW'(position);
	assign tail    = count_q - CW'(1);

	// decode the request against the current count
	always_comb begin
		req_op     = CELL_HOLD;
		req_status = STAT_DONE;
		req_count  = cnt_ext;
		req_dump   = 1'b0;
		tgt        = pos_ext;
		case (req_type)
			REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
				if (req_type == REQ_INS_FRONT)
					tgt = '0;
				else if (req_type == REQ_INS_BACK)
					tgt = cnt_ext;
				if (tgt > cnt_ext)
					req_status = STAT_RANGE;
				else if (cnt_ext >= DepthC)
					req_status = STAT_FULL;
				else begin
					req_op    = CELL_INS;
					req_count = cnt_ext + CmpW'(1);
				end
			end
			REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS: begin
				if (req_type == REQ_DEL_FRONT)
					tgt = '0;
				else if (req_type == REQ_DEL_BACK)
					tgt = cnt_ext - CmpW'(1);
				if (cnt_ext == '0)
					req_status = STAT_EMPTY;
				else if (tgt >= cnt_ext)
					req_status = STAT_RANGE;
				else begin
					req_op    = CELL_DEL;
					req_count = cnt_ext - CmpW'(1);
				end
			end
			REQ_DUMP: begin
				req_dump = (count_q != '0);
			end
			default: req_op = CELL_HOLD;
		endcase
	end

	// drive the chain: request ops when taken, rotate one step per dumped item
	always_comb begin
		ctl.new_value = new_value;
		ctl.op        = CELL_HOLD;
		if (accept)
			ctl.op = req_op;
		else if (state_q == S_DUMP && out_free)
			ctl.op = CELL_ROT;
	end

	iol_chain #(
		.DEPTH (LIST_DEPTH),
		.IW    (CW)
	) u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.pos  (tgt[CW-1:0]),
		.tail (tail),
		.head (head)
	);

	assign dump_last    = (dump_idx_q == tail);
	assign dump_cnt_ext = CmpW'(count_q);

	// sequence requests and dumps, track the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= req_count[CW-1:0];
				out_valid_q <= !req_dump;
				if (req_dump) begin
					state_q    <= S_DUMP;
					dump_idx_q <= '0;
				end
			end else if (state_q == S_DUMP && out_free) begin
				out_valid_q <= 1'b1;
				dump_idx_q  <= dump_idx_q + CW'(1);
				if (dump_last)
					state_q <= S_IDLE;
			end else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// load the result payload
	always_ff @(posedge clk) begin
		if (accept && !req_dump) begin
			status_q      <= req_status;
			item_value_q  <= '0;
			item_valid_q  <= 1'b0;
			last_q        <= 1'b1;
			entry_count_q <= req_count[4:0];
		end else if (state_q == S_DUMP && out_free) begin
			status_q      <= STAT_DONE;
			item_value_q  <= head;
			item_valid_q  <= 1'b1;
			last_q        <= dump_last;
			entry_count_q <= dump_cnt_ext[4:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign item_value  = item_value_q;
	assign item_valid  = item_valid_q;
	assign last_item   = last_q;
	assign entry_count = entry_count_q;
endmodule
`default_nettype wire
